>>> rtl/pic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg: shared definitions for the platform interrupt controller
// Bus widths, register map offsets, action codes, sequencer states and the
// control bundle that drives the shared priority compare unit.
// ----------------------------------------------------------------------------
package pic_pkg;

	// Default configuration
	localparam int unsigned NUM_SOURCES_DEF = 182;
	localparam int unsigned PRIO_BITS_DEF   = 3;

	// Fixed field widths
	localparam int unsigned ACT_W  = 2;
	localparam int unsigned ADDR_W = 22;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SID_W  = 8;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LEVEL = 2'd2;

	// Register map
	localparam logic [ADDR_W-1:0] BASE_PRIO  = 22'h000000;
	localparam logic [ADDR_W-1:0] BASE_PEND  = 22'h001000;
	localparam logic [ADDR_W-1:0] BASE_ENAB  = 22'h002000;
	localparam logic [ADDR_W-1:0] REG_THRESH = 22'h200000;
	localparam logic [ADDR_W-1:0] REG_CLAIM  = 22'h200004;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXEC   = 6'b000010,
		ST_RDWAIT = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// Control bundle for the compare unit
	typedef struct packed {
		logic clear;
		logic vld;
		logic qual;
	} scan_ctl_t;

endpackage

>>> rtl/pic_prio_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_prio_mem: source priority store
// One write port and one registered read port. A valid bit per entry, cleared
// by reset, makes an entry that was never written read as priority zero.
// ----------------------------------------------------------------------------
module pic_prio_mem
	import pic_pkg::*;
#(
	parameter int unsigned DEPTH  = NUM_SOURCES_DEF,
	parameter int unsigned ID_W   = $clog2(NUM_SOURCES_DEF),
	parameter int unsigned PRIO_W = PRIO_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ID_W-1:0]   waddr,
	input  logic [PRIO_W-1:0] wdata,
	input  logic [ID_W-1:0]   raddr,
	output logic [PRIO_W-1:0] rdata
);

	logic [PRIO_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [PRIO_W-1:0] rd_q;
	logic              rd_vld_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_vld_q <= valid_q[raddr];
		end
	end

	// Unwritten entries read as zero
	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/pic_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_scan: shared priority compare unit
// Takes one source per cycle and keeps the best candidate so far, with ties
// kept by the lower id, plus a saturating count of sources above threshold.
// ----------------------------------------------------------------------------
module pic_scan
	import pic_pkg::*;
#(
	parameter int unsigned ID_W   = $clog2(NUM_SOURCES_DEF),
	parameter int unsigned PRIO_W = PRIO_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [ID_W-1:0]   id,
	input  logic [PRIO_W-1:0] prio,
	input  logic [PRIO_W-1:0] thr,
	output logic [ID_W-1:0]   best_id,
	output logic              multi
);

	logic [ID_W-1:0]   best_id_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [1:0]        hits_q;
	logic              above_best;
	logic              above_thr;

	// Strictly greater keeps the earlier, lower id on a tie
	assign above_best = prio > best_prio_q;
	assign above_thr  = prio > thr;

	// Advance the running best and the hit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_id_q   <= '0;
			best_prio_q <= '0;
			hits_q      <= '0;
		end else if (ctl.clear) begin
			best_id_q   <= '0;
			best_prio_q <= thr;
			hits_q      <= '0;
		end else if (ctl.vld && ctl.qual) begin
			if (above_best) begin
				best_id_q   <= id;
				best_prio_q <= prio;
			end
			if (above_thr && hits_q != 2'd2) begin
				hits_q <= hits_q + 2'd1;
			end
		end
	end

	assign best_id = best_id_q;
	assign multi   = hits_q == 2'd2;

endmodule

>>> rtl/platform_interrupt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller: single-context platform interrupt controller
// Level sources, per-source priority and enable, threshold and claim/complete
// behind a word register map, with one interrupt request output.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         action, address, write_data, source_id,
//                                 source_level
//  result    done (one cycle)     read_data, irq_request
//
//  Each beat runs a scan that visits one source a cycle through the priority
//  store's single read port; a priority read adds a read wait state first.
//  busy is high from the cycle after acceptance until done is shown.
//  Reset clears all control state at once; no clearing pass is needed.
//  done is a one-cycle strobe and the receiver cannot hold it off.
// ----------------------------------------------------------------------------
module platform_interrupt_controller
	import pic_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF,
	parameter int unsigned PRIO_BITS   = PRIO_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	input  logic [SID_W-1:0]  source_id,
	input  logic              source_level,
	output logic              done,
	output logic [DATA_W-1:0] read_data,
	output logic              irq_request
);

	localparam int unsigned ID_W      = $clog2(NUM_SOURCES);
	localparam int unsigned NUM_WORDS = (NUM_SOURCES + 31) / 32;
	localparam int unsigned WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned PAD_W     = (2 ** WORD_W) * 32;
	localparam logic [ADDR_W-1:0] PEND_END = ADDR_W'(BASE_PEND + 4 * NUM_WORDS);
	localparam logic [ADDR_W-1:0] ENAB_END = ADDR_W'(BASE_ENAB + 4 * NUM_WORDS);
	localparam logic [ID_W-1:0]   LAST_ID  = ID_W'(NUM_SOURCES - 1);

	state_t state_q;

	// Latched request beat
	logic [ACT_W-1:0]  act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic [SID_W-1:0]  sid_q;
	logic              lvl_q;

	// Source flags and threshold
	logic [NUM_SOURCES-1:0] pend_q;
	logic [NUM_SOURCES-1:0] en_q;
	logic [NUM_SOURCES-1:0] insvc_q;
	logic [NUM_SOURCES-1:0] line_q;
	logic [NUM_SOURCES-1:0] en_next;
	logic [PRIO_BITS-1:0]   thr_q;

	// Working and output registers
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] read_data_q;
	logic              irq_q;
	logic              done_q;

	// Scan pipeline
	logic [ID_W-1:0] scan_idx_q;
	logic [ID_W-1:0] id_s1;
	logic            qual_s1;
	logic            vld_s1;

	// Decode
	logic [ADDR_W-1:0] prio_off;
	logic [ADDR_W-1:0] pend_off;
	logic [ADDR_W-1:0] enab_off;
	logic [9:0]        prio_id;
	logic              prio_ok;
	logic [WORD_W-1:0] pend_word;
	logic [WORD_W-1:0] enab_word;
	logic              is_prio;
	logic              is_pend;
	logic              is_enab;
	logic              is_thresh;
	logic              is_claim;
	logic              claim_rd;
	logic              sid_ok;
	logic [ID_W-1:0]   sidx;
	logic              cmp_ok;
	logic [ID_W-1:0]   cidx;
	logic [PAD_W-1:0]  pend_pad;
	logic [PAD_W-1:0]  en_pad;

	// Memory and compare unit hookup
	logic                 mem_we;
	logic [ID_W-1:0]      mem_waddr;
	logic [ID_W-1:0]      mem_raddr;
	logic [PRIO_BITS-1:0] mem_rdata;
	scan_ctl_t            scan_ctl;
	logic [ID_W-1:0]      best_id;
	logic                 multi;

	// Decode the latched address
	assign prio_off  = addr_q - BASE_PRIO;
	assign pend_off  = addr_q - BASE_PEND;
	assign enab_off  = addr_q - BASE_ENAB;
	assign prio_id   = prio_off[11:2];
	assign prio_ok   = prio_id != '0 && 32'(prio_id) < NUM_SOURCES;
	assign pend_word = pend_off[WORD_W+1:2];
	assign enab_word = enab_off[WORD_W+1:2];
	assign is_prio   = addr_q < BASE_PEND;
	assign is_pend   = addr_q >= BASE_PEND && addr_q < PEND_END;
	assign is_enab   = addr_q >= BASE_ENAB && addr_q < ENAB_END;
	assign is_thresh = addr_q == REG_THRESH;
	assign is_claim  = addr_q == REG_CLAIM;
	assign claim_rd  = act_q == ACT_READ && is_claim;
	assign sid_ok    = sid_q != '0 && 32'(sid_q) < NUM_SOURCES;
	assign sidx      = ID_W'(sid_q);
	assign cmp_ok    = data_q != '0 && data_q < NUM_SOURCES;
	assign cidx      = ID_W'(data_q);
	assign pend_pad  = PAD_W'(pend_q);
	assign en_pad    = PAD_W'(en_q);

	// Merge an enable word into the flag vector; source zero stays clear
	always_comb begin
		en_next = en_q;
		for (int i = 1; i < NUM_SOURCES; i++) begin
			if ((i >> 5) == int'(enab_word)) begin
				en_next[i] = data_q[i % 32];
			end
		end
	end

	// Priority store port use
	assign mem_we    = state_q == ST_EXEC && act_q == ACT_WRITE && is_prio && prio_ok;
	assign mem_waddr = ID_W'(prio_id);
	assign mem_raddr = (state_q == ST_EXEC) ? (prio_ok ? ID_W'(prio_id) : '0) : scan_idx_q;

	pic_prio_mem #(
		.DEPTH  (NUM_SOURCES),
		.ID_W   (ID_W),
		.PRIO_W (PRIO_BITS)
	) u_prio_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (data_q[PRIO_BITS-1:0]),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	// Clear in the first scan cycle, once a threshold write has landed
	assign scan_ctl.clear = state_q == ST_SCAN && !vld_s1;
	assign scan_ctl.vld   = vld_s1;
	assign scan_ctl.qual  = qual_s1;

	pic_scan #(
		.ID_W   (ID_W),
		.PRIO_W (PRIO_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.id      (id_s1),
		.prio    (mem_rdata),
		.thr     (thr_q),
		.best_id (best_id),
		.multi   (multi)
	);

	// Latch the request beat on acceptance
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			act_q  <= action;
			addr_q <= {address[ADDR_W-1:2], 2'b00};
			data_q <= write_data;
			sid_q  <= source_id;
			lvl_q  <= source_level;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			done_q      <= 1'b0;
			read_data_q <= '0;
			irq_q       <= 1'b0;
			rdata_q     <= '0;
		end else begin
			done_q <= state_q == ST_FINISH;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scan_idx_q <= ID_W'(1);
					if (act_q == ACT_READ && is_pend) begin
						rdata_q <= pend_pad[{pend_word, 5'b0} +: 32];
					end else if (act_q == ACT_READ && is_enab) begin
						rdata_q <= en_pad[{enab_word, 5'b0} +: 32];
					end else if (act_q == ACT_READ && is_thresh) begin
						rdata_q <= DATA_W'(thr_q);
					end else begin
						rdata_q <= '0;
					end
					state_q <= (act_q == ACT_READ && is_prio) ? ST_RDWAIT : ST_SCAN;
				end
				ST_RDWAIT: begin
					rdata_q <= prio_ok ? DATA_W'(mem_rdata) : '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_idx_q == LAST_ID) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + ID_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (claim_rd) begin
						read_data_q <= DATA_W'(best_id);
						irq_q       <= multi;
					end else begin
						read_data_q <= rdata_q;
						irq_q       <= best_id != '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Feed one source a cycle into the compare unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= state_q == ST_SCAN;
		end
	end

	always_ff @(posedge clk) begin
		id_s1   <= scan_idx_q;
		qual_s1 <= en_q[scan_idx_q] & pend_q[scan_idx_q];
	end

	// Update source flags and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			en_q    <= '0;
			insvc_q <= '0;
			line_q  <= '0;
			thr_q   <= '0;
		end else if (state_q == ST_EXEC) begin
			case (act_q)
				ACT_WRITE: begin
					if (is_enab) begin
						en_q <= en_next;
					end
					if (is_thresh) begin
						thr_q <= data_q[PRIO_BITS-1:0];
					end
					if (is_claim && cmp_ok) begin
						insvc_q[cidx] <= 1'b0;
						if (line_q[cidx]) begin
							pend_q[cidx] <= 1'b1;
						end
					end
				end
				ACT_LEVEL: begin
					if (sid_ok) begin
						line_q[sidx] <= lvl_q;
						if (lvl_q && !insvc_q[sidx]) begin
							pend_q[sidx] <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_FINISH && claim_rd && best_id != '0) begin
			pend_q[best_id]  <= 1'b0;
			insvc_q[best_id] <= 1'b1;
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign read_data   = read_data_q;
	assign irq_request = irq_q;

endmodule

>>> rtl/pic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_checker: port-level checks for the platform interrupt controller
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module pic_checker
	import pic_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [DATA_W-1:0] read_data,
	input logic              irq_request
);

	// Result is shown only once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while busy");

	// An accepted beat keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("beat accepted but block not busy");

	// Every finished beat produces a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// Outputs move only with a result
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(irq_request) && $stable(read_data))
		else $error("result ports changed without done");

	// Strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

bind platform_interrupt_controller pic_checker u_pic_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.read_data   (read_data),
	.irq_request (irq_request)
);
